// ===== design/rrfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser package
// Frame layout constants, shared types and the header byte lookup.
// ----------------------------------------------------------------------------
package rrfp_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int HDR_LEN     = 4;
  localparam int LEN_LEN     = 2;
  localparam int FTR_LEN     = 4;
  localparam int PAY_OFS     = HDR_LEN + LEN_LEN;
  localparam int MIN_FIELDS  = 11;
  localparam int MIN_FRAME   = PAY_OFS + MIN_FIELDS + FTR_LEN;
  localparam int FIELD_IDX_W = $clog2(MIN_FIELDS);
  localparam int TAIL_LEN    = 5;
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'b1;

  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 6'd11;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 6'd54;

  localparam logic [7:0] HDR_B0   = 8'hF4;
  localparam logic [7:0] HDR_B1   = 8'hF3;
  localparam logic [7:0] HDR_B2   = 8'hF2;
  localparam logic [7:0] HDR_B3   = 8'hF1;
  localparam logic [7:0] FTR_B0   = 8'hF8;
  localparam logic [7:0] FTR_B1   = 8'hF7;
  localparam logic [7:0] FTR_B2   = 8'hF6;
  localparam logic [7:0] FTR_B3   = 8'hF5;
  localparam logic [7:0] TYPE_A   = 8'h01;
  localparam logic [7:0] TYPE_B   = 8'h02;
  localparam logic [7:0] HEAD_TAG = 8'hAA;
  localparam logic [7:0] TAIL_TAG = 8'h55;
  localparam logic [7:0] TAIL_END = 8'h00;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [1:0]  target_state;
    logic        presence;
    logic        moving_target;
    logic        stationary_target;
    logic [15:0] moving_distance_cm;
    logic [7:0]  moving_energy;
    logic [15:0] stationary_distance_cm;
    logic [7:0]  stationary_energy;
    logic [15:0] detection_distance_cm;
  } result_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = HDR_B0;
      2'd1:    b = HDR_B1;
      2'd2:    b = HDR_B2;
      default: b = HDR_B3;
    endcase
    return b;
  endfunction

endpackage

// ===== design/rrfp_intf.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser channels
// Valid/ready channels for received bytes and decoded reports.
// ----------------------------------------------------------------------------
interface rrfp_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface rrfp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  target_state;
  logic        presence;
  logic        moving_target;
  logic        stationary_target;
  logic [15:0] moving_distance_cm;
  logic [7:0]  moving_energy;
  logic [15:0] stationary_distance_cm;
  logic [7:0]  stationary_energy;
  logic [15:0] detection_distance_cm;

  modport source (output valid, output target_state, output presence, output moving_target,
                  output stationary_target, output moving_distance_cm, output moving_energy,
                  output stationary_distance_cm, output stationary_energy,
                  output detection_distance_cm, input ready);
  modport sink   (input valid, input target_state, input presence, input moving_target,
                  input stationary_target, input moving_distance_cm, input moving_energy,
                  input stationary_distance_cm, input stationary_energy,
                  input detection_distance_cm, output ready);
endinterface

// ===== design/rrfp_in_reg.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser input register
// Captures one received byte per cycle and holds it while the pipe stalls.
// ----------------------------------------------------------------------------
module rrfp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  rrfp_item_if.sink      item_i,
  input  logic           advance_i,
  output rrfp_pkg::item_t stage_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       load;

  assign item_i.ready = !valid_q || advance_i;
  assign load         = item_i.valid && item_i.ready;
  assign valid_d      = item_i.ready ? item_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= item_i.data_byte;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

// ===== design/rrfp_parser.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser core
// Tracks header, length, payload and footer; captures report fields in flight.
// ----------------------------------------------------------------------------
module rrfp_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rrfp_pkg::item_t                    stage_i,
  input  logic                               advance_i,
  input  logic                               cfg_we_i,
  input  logic [rrfp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rrfp_pkg::LEN_W-1:0]         cfg_data_i,
  output logic                               done_o,
  output rrfp_pkg::result_t                  result_o
);

  localparam int CW = rrfp_pkg::CNT_W;

  logic [CW-1:0]                  cnt_q, cnt_d;
  logic [CW-1:0]                  exp_q, exp_d;
  logic [1:0]                     prog_q, prog_d;
  logic [7:0]                     len_lo_q;
  logic [rrfp_pkg::LEN_W-1:0]     min_q, max_q;
  logic [7:0]                     pay_q [rrfp_pkg::MIN_FIELDS];
  logic [7:0]                     tail_q [rrfp_pkg::TAIL_LEN];

  logic [7:0]                     b;
  logic                           step;
  logic                           hit;
  logic [CW-1:0]                  cnt_inc;
  logic                           len_bad;
  logic                           complete;
  logic                           in_field;
  logic [rrfp_pkg::FIELD_IDX_W-1:0] field_idx;
  logic [CW-1:0]                  field_ofs;
  logic                           tail_ok;
  logic                           head_ok;

  assign b         = stage_i.data;
  assign step      = stage_i.valid && advance_i;
  assign hit       = (b == rrfp_pkg::hdr_byte(prog_q));
  assign cnt_inc   = cnt_q + CW'(1);
  assign len_bad   = (b != 8'd0) || (len_lo_q < {2'b00, min_q}) || (len_lo_q > {2'b00, max_q});
  assign field_ofs = cnt_q - CW'(rrfp_pkg::PAY_OFS);
  assign field_idx = field_ofs[rrfp_pkg::FIELD_IDX_W-1:0];
  assign in_field  = (cnt_q >= CW'(rrfp_pkg::PAY_OFS)) &&
                     (cnt_q < CW'(rrfp_pkg::PAY_OFS + rrfp_pkg::MIN_FIELDS));
  assign complete  = (cnt_q != 0) && (cnt_q < CW'(rrfp_pkg::FRAME_BYTES)) &&
                     (exp_q != 0) && (cnt_inc == exp_q);

  always_comb begin
    cnt_d  = cnt_q;
    exp_d  = exp_q;
    prog_d = prog_q;
    if (cnt_q == 0) begin
      prog_d = hit ? prog_q + 2'd1 : {1'b0, b == rrfp_pkg::HDR_B0};
      if (hit && prog_q == 2'd3) begin
        cnt_d = CW'(rrfp_pkg::HDR_LEN);
      end
    end else if (cnt_q >= CW'(rrfp_pkg::FRAME_BYTES)) begin
      cnt_d  = '0;
      exp_d  = '0;
      prog_d = {1'b0, b == rrfp_pkg::HDR_B0};
    end else begin
      cnt_d = cnt_inc;
      if (cnt_inc == CW'(rrfp_pkg::PAY_OFS)) begin
        if (len_bad) begin
          cnt_d  = '0;
          prog_d = {1'b0, b == rrfp_pkg::HDR_B0};
        end else begin
          exp_d = CW'(len_lo_q[rrfp_pkg::LEN_W-1:0]) +
                  CW'(rrfp_pkg::PAY_OFS + rrfp_pkg::FTR_LEN);
        end
      end
      if (complete) begin
        cnt_d  = '0;
        exp_d  = '0;
        prog_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      exp_q  <= '0;
      prog_q <= '0;
      min_q  <= rrfp_pkg::MIN_LEN_RESET;
      max_q  <= rrfp_pkg::MAX_LEN_RESET;
    end else begin
      if (step) begin
        cnt_q  <= cnt_d;
        exp_q  <= exp_d;
        prog_q <= prog_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rrfp_pkg::CFG_MIN_LEN: min_q <= cfg_data_i;
          rrfp_pkg::CFG_MAX_LEN: max_q <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      if (cnt_q == CW'(rrfp_pkg::HDR_LEN)) begin
        len_lo_q <= b;
      end
      if (in_field) begin
        pay_q[field_idx] <= b;
      end
      tail_q[0] <= b;
      for (int i = 1; i < rrfp_pkg::TAIL_LEN; i++) begin
        tail_q[i] <= tail_q[i-1];
      end
    end
  end

  assign tail_ok = (tail_q[4] == rrfp_pkg::TAIL_TAG) && (tail_q[3] == rrfp_pkg::TAIL_END) &&
                   (tail_q[2] == rrfp_pkg::FTR_B0) && (tail_q[1] == rrfp_pkg::FTR_B1) &&
                   (tail_q[0] == rrfp_pkg::FTR_B2) && (b == rrfp_pkg::FTR_B3);
  assign head_ok = ((pay_q[0] == rrfp_pkg::TYPE_A) || (pay_q[0] == rrfp_pkg::TYPE_B)) &&
                   (pay_q[1] == rrfp_pkg::HEAD_TAG);

  assign done_o = stage_i.valid && complete && tail_ok && head_ok &&
                  (exp_q >= CW'(rrfp_pkg::MIN_FRAME));

  assign result_o.target_state           = pay_q[2][1:0];
  assign result_o.presence               = |pay_q[2][1:0];
  assign result_o.moving_target          = pay_q[2][0];
  assign result_o.stationary_target      = pay_q[2][1];
  assign result_o.moving_distance_cm     = {pay_q[4], pay_q[3]};
  assign result_o.moving_energy          = pay_q[5];
  assign result_o.stationary_distance_cm = {pay_q[7], pay_q[6]};
  assign result_o.stationary_energy      = pay_q[8];
  assign result_o.detection_distance_cm  = {pay_q[10], pay_q[9]};

endmodule

// ===== design/rrfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser result register
// Holds one decoded report until the sink takes it.
// ----------------------------------------------------------------------------
module rrfp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              done_i,
  input  rrfp_pkg::result_t result_i,
  output logic              advance_o,
  rrfp_result_if.source     result_o
);

  logic              valid_q;
  rrfp_pkg::result_t res_q;

  assign advance_o = !valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= done_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && done_i) begin
      res_q <= result_i;
    end
  end

  assign result_o.valid                  = valid_q;
  assign result_o.target_state           = res_q.target_state;
  assign result_o.presence               = res_q.presence;
  assign result_o.moving_target          = res_q.moving_target;
  assign result_o.stationary_target      = res_q.stationary_target;
  assign result_o.moving_distance_cm     = res_q.moving_distance_cm;
  assign result_o.moving_energy          = res_q.moving_energy;
  assign result_o.stationary_distance_cm = res_q.stationary_distance_cm;
  assign result_o.stationary_energy      = res_q.stationary_energy;
  assign result_o.detection_distance_cm  = res_q.detection_distance_cm;

endmodule

// ===== design/radar_report_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser
// Scans a radar byte stream for report frames and emits one decoded report
// for each frame that passes header, length, marker and footer checks.
//
//   channel   dir  carries
//   item_i    in   data_byte, one received byte
//   result_o  out  target state, flags, distances, energies
//   cfg       in   min/max payload length writes
//
// One byte per cycle unless the pipe holds; each report leaves registered.
// The pipe is an input register and a result register; the whole pipe holds
// only while a waiting report is not taken.
// Reset clears the frame tracker and loads the length limits to 11 and 54.
// ----------------------------------------------------------------------------
module radar_report_frame_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rrfp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rrfp_pkg::LEN_W-1:0]     cfg_data_i,
  rrfp_item_if.sink                      item_i,
  rrfp_result_if.source                  result_o
);

  rrfp_pkg::item_t   stage;
  rrfp_pkg::result_t result;
  logic              advance;
  logic              done;

  rrfp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  rrfp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (stage),
    .advance_i  (advance),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done),
    .result_o   (result)
  );

  rrfp_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .done_i    (done),
    .result_i  (result),
    .advance_o (advance),
    .result_o  (result_o)
  );

endmodule

// ===== design/rrfp_checker.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser checker
// Port-level checks on stalls, report spacing and latency.
// ----------------------------------------------------------------------------
module rrfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_state_i,
  input logic [15:0] out_dist_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("report dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_state_i) && $stable(out_dist_i))
    else $error("report changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i)
    else $error("reports closer than one frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("report without a byte two cycles earlier");

endmodule

bind radar_report_frame_parser rrfp_checker u_rrfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_state_i (result_o.target_state),
  .out_dist_i  (result_o.moving_distance_cm)
);
